### rtl/mped_pkg.sv
// ----------------------------------------------------------------------------
// Edge debouncer package
// Shared widths, codes and types of the multi-pin edge debouncer.
// ----------------------------------------------------------------------------
package mped_pkg;

	// sampled level vector and per-pin mask width
	localparam int unsigned LVL_W   = 8;
	// holdoff counter width
	localparam int unsigned HOLD_W  = 8;
	// reported pin index width
	localparam int unsigned IDX_W   = 3;
	// configuration port widths
	localparam int unsigned CFG_A_W = 2;
	localparam int unsigned CFG_D_W = 8;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_INIT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_A_W-1:0] CFG_RISE_MASK    = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_FALL_MASK    = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_RESTART_MASK = 2'd2;
	localparam logic [CFG_A_W-1:0] CFG_HOLDOFF      = 2'd3;

	// configuration reset values
	localparam logic [CFG_D_W-1:0] RST_RISE_MASK    = 8'hFF;
	localparam logic [CFG_D_W-1:0] RST_FALL_MASK    = 8'h00;
	localparam logic [CFG_D_W-1:0] RST_RESTART_MASK = 8'h00;
	localparam logic [HOLD_W-1:0]  RST_HOLDOFF      = 8'd20;

	// per-pin settings handed to a lane
	typedef struct packed {
		logic              rise_en;
		logic              fall_en;
		logic              restart;
		logic [HOLD_W-1:0] holdoff;
	} lane_cfg_t;

	// per-pin event flags from a lane
	typedef struct packed {
		logic hit;
		logic rising;
	} lane_evt_t;

endpackage

### rtl/multi_pin_edge_debouncer_core.sv
// ----------------------------------------------------------------------------
// Multi-pin edge debouncer
// Reports enabled pin edges with a per-pin holdoff; the highest pin wins.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle; the input register, the pin lanes and
// the result register form one short pass, stalled only by a full result slot.
// Reset: clears levels, holdoff counters and valid flags, and loads the
// register defaults (rise mask all ones, fall and restart masks zero, holdoff 20).
module multi_pin_edge_debouncer_core import mped_pkg::*; #(
	parameter int unsigned PIN_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_idx,
	input  logic [CFG_D_W-1:0] cfg_data,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [LVL_W-1:0]   s_tdata,   // [7:0] pin_levels
	input  logic [0:0]         s_tuser,   // [0] kind
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [2:0] pin_index, [7:3] zero
	output logic [0:0]         m_tuser    // [0] rising
);

	logic [LVL_W-1:0]  rise_mask_q;
	logic [LVL_W-1:0]  fall_mask_q;
	logic [LVL_W-1:0]  restart_mask_q;
	logic [HOLD_W-1:0] holdoff_q;

	logic              valid_s1;
	logic              kind_s1;
	logic [LVL_W-1:0]  levels_s1;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_rising_q;

	logic              out_free;
	logic              retire;
	logic              ev_any;
	logic [IDX_W-1:0]  ev_idx;
	logic              ev_rising;

	lane_evt_t         lane_evt [PIN_COUNT];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_mask_q    <= RST_RISE_MASK;
			fall_mask_q    <= RST_FALL_MASK;
			restart_mask_q <= RST_RESTART_MASK;
			holdoff_q      <= RST_HOLDOFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RISE_MASK:    rise_mask_q    <= cfg_data;
				CFG_FALL_MASK:    fall_mask_q    <= cfg_data;
				CFG_RESTART_MASK: restart_mask_q <= cfg_data;
				CFG_HOLDOFF:      holdoff_q      <= cfg_data;
				default:          ;
			endcase
		end
	end

	// handshake: the beat in stage 1 leaves whenever the result slot can take it
	assign out_free = !out_valid_q || m_tready;
	assign retire   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= s_tuser[0];
			levels_s1 <= s_tdata;
		end
	end

	// pin lanes; pins past the level vector see zero and have no enables
	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
		logic      lvl;
		lane_cfg_t lcfg;
		if (g < LVL_W) begin : g_real
			assign lvl          = levels_s1[g];
			assign lcfg.rise_en = rise_mask_q[g];
			assign lcfg.fall_en = fall_mask_q[g];
			assign lcfg.restart = restart_mask_q[g];
		end else begin : g_pad
			assign lvl          = 1'b0;
			assign lcfg.rise_en = 1'b0;
			assign lcfg.fall_en = 1'b0;
			assign lcfg.restart = 1'b0;
		end
		assign lcfg.holdoff = holdoff_q;

		mped_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.update (retire),
			.kind   (kind_s1),
			.level  (lvl),
			.cfg    (lcfg),
			.evt    (lane_evt[g])
		);
	end

	// pick the event of the highest reporting pin
	always_comb begin
		ev_any    = 1'b0;
		ev_idx    = '0;
		ev_rising = 1'b0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (lane_evt[i].hit) begin
				ev_any    = 1'b1;
				ev_idx    = IDX_W'(i);
				ev_rising = lane_evt[i].rising;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= retire && ev_any;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && ev_any) begin
			out_idx_q    <= ev_idx;
			out_rising_q <= ev_rising;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {{(8 - IDX_W){1'b0}}, out_idx_q};
	assign m_tuser[0] = out_rising_q;

	// a stalled stage-1 beat keeps its place and payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(levels_s1) && $stable(kind_s1))
		else $error("stage 1 beat lost during stall");

	// input side never takes a beat while stage 1 is blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && valid_s1 && !out_free))
		else $error("input taken while stage 1 blocked");

	// a freshly loaded result names a pin whose edge kind is enabled
	a_evt_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		retire && ev_any |=> (m_tuser[0] ? rise_mask_q[out_idx_q] : fall_mask_q[out_idx_q]))
		else $error("reported edge not enabled");

endmodule

### rtl/mped_lane.sv
// ----------------------------------------------------------------------------
// Edge debouncer pin lane
// Holds one pin's previous level and holdoff counter and flags its edge event.
// ----------------------------------------------------------------------------
module mped_lane import mped_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      update,   // a beat retires this cycle
	input  logic      kind,
	input  logic      level,
	input  lane_cfg_t cfg,
	output lane_evt_t evt
);

	logic              prev_q;
	logic [HOLD_W-1:0] cnt_q;
	logic [HOLD_W-1:0] cnt_nxt;
	logic              changed;
	logic              enabled;
	logic              cnt_zero;

	assign changed  = level ^ prev_q;
	assign enabled  = level ? cfg.rise_en : cfg.fall_en;
	assign cnt_zero = (cnt_q == '0);

	// work out next counter and the event flag
	always_comb begin
		cnt_nxt    = cnt_q;
		evt.hit    = 1'b0;
		evt.rising = level;
		if (kind == KIND_TICK) begin
			if (changed) begin
				if (enabled) begin
					if (cnt_zero) begin
						cnt_nxt = cfg.holdoff;
						evt.hit = 1'b1;
					end else if (cfg.restart) begin
						cnt_nxt = cfg.holdoff;
					end else begin
						cnt_nxt = cnt_q - 1'b1;
					end
				end
			end else if (!cnt_zero) begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
	end

	// hold state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			cnt_q  <= '0;
		end else if (update) begin
			prev_q <= level;
			cnt_q  <= cnt_nxt;
		end
	end

endmodule

### sim/tb_multi_pin_edge_debouncer_core.sv
// ----------------------------------------------------------------------------
// Testbench for the multi-pin edge debouncer core
// Streams tick and init beats with random gaps and result back-pressure, keeps
// a cycle-free model of the pin levels and holdoff counters, and compares
// every result beat with the oldest predicted pin event.
// ----------------------------------------------------------------------------
module tb_multi_pin_edge_debouncer_core;
	import mped_pkg::*;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int PIPE_SETTLE    = 4;

	typedef struct packed {
		logic             kind;
		logic [LVL_W-1:0] levels;
	} tick_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] pin;
		logic             rising;
	} pin_event_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_A_W-1:0] cfg_idx;
	logic [CFG_D_W-1:0] cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [LVL_W-1:0]   s_tdata;   // [7:0] pin_levels
	logic [0:0]         s_tuser;   // [0] kind
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // [2:0] pin_index, [7:3] zero
	logic [0:0]         m_tuser;   // [0] rising

	// debouncer model: settings and per-pin state
	logic [LVL_W-1:0]  rise_mask    = RST_RISE_MASK;
	logic [LVL_W-1:0]  fall_mask    = RST_FALL_MASK;
	logic [LVL_W-1:0]  restart_bits = RST_RESTART_MASK;
	logic [HOLD_W-1:0] holdoff_load = RST_HOLDOFF;
	logic [LVL_W-1:0]  last_level   = '0;
	logic [HOLD_W-1:0] hold_cnt [LVL_W];

	tick_item_t tick_q [$];
	pin_event_t pin_evt_q [$];

	logic [LVL_W-1:0] queued_level = '0;
	bit         in_beat    = 1'b0;
	bit         calm       = 1'b0;
	int         src_gap    = 0;
	int         snk_gap    = 0;
	int         idle_ticks = 0;
	int         errors     = 0;
	pin_event_t predicted;
	pin_event_t want;
	tick_item_t next_item;

	multi_pin_edge_debouncer_core #(.PIN_COUNT(8)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// run the clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// advance the model by one beat; return 1 when a pin event is reported
	function automatic bit debounce_tick(input logic kind, input logic [LVL_W-1:0] lv,
			output pin_event_t ev);
		bit                hit;
		logic [HOLD_W-1:0] cnt;
		logic              now_lv;
		hit = 1'b0;
		ev  = '0;
		if (kind == KIND_INIT) begin
			last_level = lv;
			return 1'b0;
		end
		for (int p = 0; p < LVL_W; p++) begin
			now_lv = lv[p];
			cnt    = hold_cnt[p];
			if (now_lv != last_level[p]) begin
				// edge: report when out of holdoff, else restart or count down
				if (now_lv ? rise_mask[p] : fall_mask[p]) begin
					if (cnt != '0) begin
						cnt = restart_bits[p] ? holdoff_load : cnt - 1'b1;
					end else begin
						cnt       = holdoff_load;
						hit       = 1'b1;
						ev.pin    = IDX_W'(p);
						ev.rising = now_lv;
					end
				end
				last_level[p] = now_lv;
			end else if (cnt != '0) begin
				cnt = cnt - 1'b1;
			end
			hold_cnt[p] = cnt;
		end
		return hit;
	endfunction

	// drive input beats from the pending queue, with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_beat) begin
				// hold the beat until it is taken
			end else if (src_gap > 0) begin
				src_gap  = src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				next_item = tick_q.pop_front();
				s_tvalid  <= 1'b1;
				s_tdata   <= next_item.levels;
				s_tuser   <= next_item.kind;
				if (!calm && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 5);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// drive result back-pressure in random bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap  = snk_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					snk_gap = $urandom_range(1, 5);
			end
		end
	end

	// track register writes, predict accepted beats, check results
	always @(posedge clk) begin
		if (arst_n) begin
			in_beat = s_tvalid && s_tready;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RISE_MASK:    rise_mask    = cfg_data;
					CFG_FALL_MASK:    fall_mask    = cfg_data;
					CFG_RESTART_MASK: restart_bits = cfg_data;
					CFG_HOLDOFF:      holdoff_load = cfg_data;
					default: ;
				endcase
			end
			if (in_beat && debounce_tick(s_tuser[0], s_tdata, predicted))
				pin_evt_q.push_back(predicted);
			if (m_tvalid && m_tready) begin
				if (pin_evt_q.size() == 0) begin
					$error("unexpected result beat: pin_index %0d rising %0d",
						m_tdata[IDX_W-1:0], m_tuser[0]);
					errors++;
				end else begin
					want = pin_evt_q.pop_front();
					if (m_tdata[IDX_W-1:0] !== want.pin) begin
						$error("pin_index: expected %0d, got %0d", want.pin,
							m_tdata[IDX_W-1:0]);
						errors++;
					end
					if (m_tuser[0] !== want.rising) begin
						$error("rising: expected %0d, got %0d", want.rising, m_tuser[0]);
						errors++;
					end
					if (m_tdata[7:IDX_W] !== '0) begin
						$error("tdata padding: expected 0, got %0h", m_tdata[7:IDX_W]);
						errors++;
					end
				end
			end
			// count cycles with no traffic at all
			if (in_beat || (m_tvalid && m_tready) || cfg_we)
				idle_ticks = 0;
			else
				idle_ticks++;
			if (idle_ticks >= WATCHDOG_LIMIT) begin
				$display("tb_multi_pin_edge_debouncer_core: done, errors");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] rise, input logic [7:0] fall,
			input logic [7:0] restart, input logic [7:0] hold);
		write_reg(CFG_RISE_MASK, rise);
		write_reg(CFG_FALL_MASK, fall);
		write_reg(CFG_RESTART_MASK, restart);
		write_reg(CFG_HOLDOFF, hold);
	endtask

	// wait until every beat is taken and every result has come, then settle
	task automatic drain();
		while (tick_q.size() != 0 || s_tvalid || pin_evt_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic push_item(input logic kind, input logic [LVL_W-1:0] lv);
		tick_q.push_back('{kind: kind, levels: lv});
		queued_level = lv;
	endtask

	// mostly bouncing pins: flip one or two bits, with some jumps and inits
	task automatic queue_random(input int count);
		logic [LVL_W-1:0] lv;
		int               roll;
		for (int n = 0; n < count; n++) begin
			lv   = queued_level;
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				push_item(KIND_INIT, LVL_W'($urandom));
			end else begin
				if (roll < 15)
					lv = LVL_W'($urandom);
				else if (roll >= 25) begin
					lv = lv ^ (LVL_W'(1) << $urandom_range(0, LVL_W - 1));
					if ($urandom_range(0, 2) == 0)
						lv = lv ^ (LVL_W'(1) << $urandom_range(0, LVL_W - 1));
				end
				push_item(KIND_TICK, lv);
			end
		end
	endtask

	initial begin
		for (int p = 0; p < LVL_W; p++)
			hold_cnt[p] = '0;
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: rising edges only, holdoff 20
		push_item(KIND_TICK, 8'h00);
		push_item(KIND_TICK, 8'hFF);   // all pins rise, highest wins
		push_item(KIND_TICK, 8'h00);   // falls disabled, counters kept
		push_item(KIND_TICK, 8'h01);   // rise inside holdoff, count down
		push_item(KIND_INIT, 8'hAA);   // capture only
		push_item(KIND_TICK, 8'hAA);
		push_item(KIND_TICK, 8'h55);
		push_item(KIND_INIT, 8'hFF);
		drain();

		// split masks, restart on half the pins, zero holdoff
		set_config(8'h0F, 8'hF0, 8'hA5, 8'd0);
		push_item(KIND_INIT, 8'h00);
		for (int n = 0; n < 5; n++) begin
			push_item(KIND_TICK, 8'hFF);
			push_item(KIND_TICK, 8'h00);
		end
		push_item(KIND_TICK, 8'h80);
		push_item(KIND_TICK, 8'h7F);
		push_item(KIND_TICK, 8'h01);
		drain();

		// random phases over a spread of settings
		set_config(8'hFF, 8'hFF, 8'h00, 8'd3);
		queue_random(150);
		drain();
		set_config(8'hFF, 8'hFF, 8'hFF, 8'd2);
		queue_random(150);
		drain();
		set_config(8'h00, 8'hFF, 8'($urandom), 8'd0);
		queue_random(150);
		drain();
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)));
		queue_random(150);
		drain();
		set_config(8'hFF, 8'h00, 8'h00, 8'd255);
		queue_random(150);
		drain();
		set_config(8'h00, 8'h00, 8'hFF, 8'd1);
		queue_random(150);
		drain();
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 255)));
		queue_random(150);
		drain();

		// last phase at full rate on both sides
		set_config(8'hFF, 8'hFF, 8'($urandom), 8'd1);
		calm = 1'b1;
		queue_random(150);
		drain();

		if (errors == 0)
			$display("tb_multi_pin_edge_debouncer_core: done, clean");
		else
			$display("tb_multi_pin_edge_debouncer_core: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/mped_pkg.sv
rtl/mped_lane.sv
rtl/multi_pin_edge_debouncer_core.sv
sim/tb_multi_pin_edge_debouncer_core.sv
